[src/cbr_pkg.sv]
// package for the comb bank reverb: constants and types
`default_nettype none
package cbr_pkg;
    localparam int MaxDelay = 16384;
    localparam int NumLines = 4;
    localparam int NumChannels = 2;
    localparam int PosBits = $clog2(MaxDelay);
    localparam int LineBits = $clog2(NumLines);
    localparam int SlotBits = $clog2(NumLines * NumChannels);
    localparam int AddrBits = SlotBits + PosBits;
    localparam int StoreDepth = MaxDelay * NumLines * NumChannels;

    localparam logic [2:0] REG_WET = 3'd0;
    localparam logic [2:0] REG_ROOM = 3'd1;
    localparam logic [2:0] REG_LEN_A = 3'd2;
    localparam logic [2:0] REG_LEN_B = 3'd3;
    localparam logic [2:0] REG_LEN_C = 3'd4;
    localparam logic [2:0] REG_LEN_D = 3'd5;
    localparam logic [2:0] REG_COEFFS = 3'd6;

    localparam logic signed [15:0] Lim8 = 16'sd26214;

    typedef enum logic [11:0] {
        ST_CLEAR = 12'b000000000001,
        ST_IDLE  = 12'b000000000010,
        ST_READ  = 12'b000000000100,
        ST_DAMP  = 12'b000000001000,
        ST_FB1   = 12'b000000010000,
        ST_FB2   = 12'b000000100000,
        ST_WRITE = 12'b000001000000,
        ST_MIX1  = 12'b000010000000,
        ST_MIX2  = 12'b000100000000,
        ST_MIX3  = 12'b001000000000,
        ST_MIX4  = 12'b010000000000,
        ST_OUT   = 12'b100000000000
    } state_t;
endpackage
`default_nettype wire

[src/comb_bank_reverb_unit.sv]
// comb bank reverb: four feedback comb lines per channel sharing one delay memory
//
// input channel s_valid/s_ready carries s_sample_in and s_channel, one item per
// sample; the result channel m_valid/m_ready carries m_sample_out.
// config writes (cfg_wr_en, cfg_index, cfg_data) take effect at once and are
// meant for times when no item is in flight.
// each line steps through read, damp, two multiply steps and write back; the
// mix steps and the output load follow, and when the result is loaded m_valid
// rises and s_ready returns together, so no new item is taken before then.
// with wet level at or below 65 the sample passes unchanged to the output load,
// the line state untouched.
// after reset a clearing pass writes zeros to all 131072 memory entries, one
// per cycle; s_ready stays low until the pass is done.
// a finished result waits in the output register while the receiver stalls; one
// more item is taken and held finished until that register frees, and s_ready
// stays low meanwhile.
`default_nettype none
module comb_bank_reverb_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic signed [15:0] s_sample_in,
    input  wire logic        s_channel,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic signed [15:0] m_sample_out,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [59:0] cfg_data
);
    logic [16:0] wet_reg, room_reg;
    logic [13:0] len_reg [cbr_pkg::NumLines];
    logic [59:0] coeff_reg;

    logic signed [15:0] mem [cbr_pkg::StoreDepth];
    logic signed [15:0] rd_data_reg;
    logic [cbr_pkg::PosBits-1:0] wp_reg [cbr_pkg::NumLines * cbr_pkg::NumChannels];

    cbr_pkg::state_t state_reg;
    logic [cbr_pkg::AddrBits-1:0] clr_reg;
    logic [cbr_pkg::LineBits-1:0] line_reg;
    logic signed [15:0] x_reg;
    logic ch_reg;
    logic [16:0] rs_reg;
    logic signed [16:0] damped_reg;
    logic signed [18:0] sum_reg;
    logic signed [31:0] prod_reg;
    logic signed [47:0] xterm_reg;
    logic signed [47:0] acc_reg;
    logic signed [18:0] wet1_reg, wet2_reg;
    logic [16:0] dryg_reg;
    logic signed [33:0] dry_reg;
    logic signed [33:0] mix_reg;
    logic signed [15:0] res_reg;
    logic out_full_reg;

    logic [16:0] wl, room;
    logic signed [17:0] wl_s, rs_s, dryg_s;
    logic signed [16:0] pan;
    logic [cbr_pkg::SlotBits-1:0] slot;
    logic [cbr_pkg::PosBits-1:0] wp, rp, len_c;
    logic signed [15:0] coeff;
    logic signed [47:0] acc_half;
    logic signed [15:0] fb_rnd, fb_sat;
    logic signed [33:0] mix_half;
    logic signed [17:0] mix_rnd;
    logic signed [15:0] mix_sat;
    logic mem_we;
    logic [cbr_pkg::AddrBits-1:0] mem_waddr;
    logic signed [15:0] mem_wdata;
    logic take, load_out;

    assign wl = (wet_reg > 17'd65536) ? 17'd65536 : wet_reg;
    assign room = (room_reg > 17'd65536) ? 17'd65536 : room_reg;
    assign wl_s = $signed({1'b0, wl});
    assign rs_s = $signed({1'b0, rs_reg});
    assign dryg_s = $signed({1'b0, dryg_reg});
    // right channel panned down to 0.8
    assign pan = ch_reg ? 17'sd26214 : 17'sd32768;
    assign slot = (cbr_pkg::SlotBits)'({ch_reg, line_reg});
    assign wp = wp_reg[slot];
    assign len_c = (len_reg[line_reg] == 14'd0) ? (cbr_pkg::PosBits)'(1) :
                   (cbr_pkg::PosBits)'(len_reg[line_reg]);
    assign rp = wp - len_c;
    assign coeff = $signed({1'b0, coeff_reg[15*line_reg +: 15]});
    assign acc_half = acc_reg + 48'sd2147483648;
    assign fb_rnd = acc_half[47:32];
    assign fb_sat = (fb_rnd > cbr_pkg::Lim8) ? cbr_pkg::Lim8 :
                    (fb_rnd < -cbr_pkg::Lim8) ? -cbr_pkg::Lim8 : fb_rnd;
    assign mix_half = mix_reg + 34'sd32768;
    assign mix_rnd = mix_half[33:16];
    assign mix_sat = (mix_rnd > 18'sd32767) ? 16'sh7FFF :
                     (mix_rnd < -18'sd32768) ? 16'sh8000 : mix_rnd[15:0];
    assign s_ready = (state_reg == cbr_pkg::ST_IDLE);
    assign take = s_valid && s_ready;
    assign load_out = (state_reg == cbr_pkg::ST_OUT) && (!out_full_reg || m_ready);
    assign m_valid = out_full_reg;

    always_comb begin
        mem_we = 1'b0;
        mem_waddr = {slot, wp};
        mem_wdata = fb_sat;
        if (state_reg == cbr_pkg::ST_CLEAR) begin
            mem_we = 1'b1;
            mem_waddr = clr_reg;
            mem_wdata = '0;
        end else if (state_reg == cbr_pkg::ST_WRITE) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[{slot, rp}];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wet_reg <= '0;
            room_reg <= 17'd32768;
            len_reg[0] <= 14'd1000;
            len_reg[1] <= 14'd1200;
            len_reg[2] <= 14'd1400;
            len_reg[3] <= 14'd1600;
            coeff_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                cbr_pkg::REG_WET: wet_reg <= cfg_data[16:0];
                cbr_pkg::REG_ROOM: room_reg <= cfg_data[16:0];
                cbr_pkg::REG_LEN_A: len_reg[0] <= cfg_data[13:0];
                cbr_pkg::REG_LEN_B: len_reg[1] <= cfg_data[13:0];
                cbr_pkg::REG_LEN_C: len_reg[2] <= cfg_data[13:0];
                cbr_pkg::REG_LEN_D: len_reg[3] <= cfg_data[13:0];
                cbr_pkg::REG_COEFFS: coeff_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cbr_pkg::ST_CLEAR;
            clr_reg <= '0;
            out_full_reg <= 1'b0;
            line_reg <= '0;
            ch_reg <= 1'b0;
            for (int i = 0; i < cbr_pkg::NumLines * cbr_pkg::NumChannels; i++)
                wp_reg[i] <= '0;
        end else begin
            if (load_out) begin
                m_sample_out <= res_reg;
                out_full_reg <= 1'b1;
            end else if (m_ready) begin
                out_full_reg <= 1'b0;
            end
            case (state_reg)
                cbr_pkg::ST_CLEAR: begin
                    clr_reg <= clr_reg + (cbr_pkg::AddrBits)'(1);
                    if (&clr_reg) state_reg <= cbr_pkg::ST_IDLE;
                end
                cbr_pkg::ST_IDLE: begin
                    if (take) begin
                        x_reg <= s_sample_in;
                        ch_reg <= s_channel;
                        line_reg <= '0;
                        sum_reg <= '0;
                        res_reg <= s_sample_in;
                        // room scale, Q0.16
                        rs_reg <= 17'(32'd13107 + ((32'(room) * 32'd19661 + 32'd32768) >> 16));
                        if (wl <= 17'd65) begin
                            state_reg <= cbr_pkg::ST_OUT;
                        end else begin
                            state_reg <= cbr_pkg::ST_READ;
                        end
                    end
                end
                cbr_pkg::ST_READ: state_reg <= cbr_pkg::ST_DAMP;
                cbr_pkg::ST_DAMP: begin
                    damped_reg <= 17'((32'(rd_data_reg) * 32'sd29491 + 32'sd16384) >>> 15);
                    state_reg <= cbr_pkg::ST_FB1;
                end
                cbr_pkg::ST_FB1: begin
                    sum_reg <= sum_reg + 19'(damped_reg);
                    prod_reg <= 32'(damped_reg) * 32'(coeff);
                    xterm_reg <= 48'(x_reg) * 48'sd1288490189;
                    state_reg <= cbr_pkg::ST_FB2;
                end
                cbr_pkg::ST_FB2: begin
                    acc_reg <= xterm_reg + 48'(prod_reg) * 48'(rs_s);
                    state_reg <= cbr_pkg::ST_WRITE;
                end
                cbr_pkg::ST_WRITE: begin
                    wp_reg[slot] <= wp + (cbr_pkg::PosBits)'(1);
                    line_reg <= line_reg + (cbr_pkg::LineBits)'(1);
                    if (line_reg == (cbr_pkg::LineBits)'(cbr_pkg::NumLines - 1))
                        state_reg <= cbr_pkg::ST_MIX1;
                    else
                        state_reg <= cbr_pkg::ST_READ;
                end
                cbr_pkg::ST_MIX1: begin
                    wet1_reg <= 19'((36'(sum_reg) * 36'(pan) + 36'sd16384) >>> 15);
                    dryg_reg <= 17'(34'd65536 - ((34'(wl) * 34'd52429 + 34'd32768) >> 16));
                    state_reg <= cbr_pkg::ST_MIX2;
                end
                cbr_pkg::ST_MIX2: begin
                    wet2_reg <= 19'((37'(wet1_reg) * 37'(wl_s) + 37'sd32768) >>> 16);
                    dry_reg <= 34'(x_reg) * 34'(dryg_s);
                    state_reg <= cbr_pkg::ST_MIX3;
                end
                cbr_pkg::ST_MIX3: begin
                    mix_reg <= dry_reg + 34'(wet2_reg) * 34'sd4915;
                    state_reg <= cbr_pkg::ST_MIX4;
                end
                cbr_pkg::ST_MIX4: begin
                    res_reg <= mix_sat;
                    state_reg <= cbr_pkg::ST_OUT;
                end
                cbr_pkg::ST_OUT: begin
                    if (load_out) state_reg <= cbr_pkg::ST_IDLE;
                end
                default: state_reg <= cbr_pkg::ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[tb/comb_bank_reverb_unit_test.sv]
// testbench for the comb bank reverb unit: directed and random stimulus checked against a built-in predictor
`default_nettype none
module comb_bank_reverb_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               chan;
    } sample_item_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [15:0] s_sample_in = '0;
    logic s_channel = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [15:0] m_sample_out;
    logic cfg_wr_en = 1'b0;
    logic [2:0] cfg_index = cbr_pkg::REG_WET;
    logic [59:0] cfg_data = '0;

    comb_bank_reverb_unit u_top (.*);

    always #5 aclk = ~aclk;

    // predictor state
    logic [16:0] mdl_wet, mdl_room;
    logic [13:0] mdl_len [4];
    logic [59:0] mdl_coeffs;
    logic signed [15:0] mdl_line [cbr_pkg::NumLines*cbr_pkg::NumChannels][cbr_pkg::MaxDelay];
    int unsigned mdl_wpos [cbr_pkg::NumLines*cbr_pkg::NumChannels];

    sample_item_t pending_items [$];
    logic signed [15:0] expected_samples [$];
    int errors = 0;
    int n_sent = 0, n_recv = 0;
    bit hold_off = 1'b0;

    function automatic longint rnd_shift(longint v, int s);
        longint d, t, q;
        d = longint'(1) << s;
        t = v + (d >>> 1);
        q = t / d;
        if (t % d != 0 && t < 0) q -= 1;
        return q;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic logic signed [15:0] reverb_sample(sample_item_t it);
        longint x, wl, room, rs, acc, pan, wet, dry, y, d, damped, fb, coeff;
        int unsigned slot, len, wp, rp;
        x = $signed(it.sample);
        wl = mdl_wet > 65536 ? 65536 : mdl_wet;
        room = mdl_room > 65536 ? 65536 : mdl_room;
        if (wl <= 65) return it.sample;
        rs = 13107 + rnd_shift(room * 19661, 16);
        acc = 0;
        for (int i = 0; i < cbr_pkg::NumLines; i++) begin
            slot = it.chan * cbr_pkg::NumLines + i;
            len = mdl_len[i];
            if (len < 1) len = 1;
            wp = mdl_wpos[slot];
            rp = (wp + cbr_pkg::MaxDelay - len) % cbr_pkg::MaxDelay;
            coeff = (mdl_coeffs >> (15 * i)) & 60'h7FFF;
            d = mdl_line[slot][rp];
            damped = rnd_shift(d * 29491, 15);
            acc += damped;
            fb = x * 64'sd1288490189 + damped * coeff * rs;
            fb = clip(rnd_shift(fb, 32), -26214, 26214);
            mdl_line[slot][wp] = 16'(fb);
            mdl_wpos[slot] = (wp + 1) % cbr_pkg::MaxDelay;
        end
        pan = it.chan ? 26214 : 32768;
        wet = rnd_shift(acc * pan, 15);
        wet = rnd_shift(wet * wl, 16) * 4915;
        dry = x * (65536 - rnd_shift(wl * 52429, 16));
        y = clip(rnd_shift(dry + wet, 16), -32768, 32767);
        return 16'(y);
    endfunction

    // driver
    int tx_gap = 0;
    always @(posedge aclk) begin
        if (s_valid && s_ready) begin
            expected_samples.push_back(reverb_sample(sample_item_t'{s_sample_in, s_channel}));
            n_sent++;
        end
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
                s_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                sample_item_t it;
                it = pending_items.pop_front();
                s_sample_in <= it.sample;
                s_channel <= it.chan;
                s_valid <= 1'b1;
                tx_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor
    int rx_gap = 0;
    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            n_recv++;
            if (expected_samples.size() == 0) begin
                $error("unexpected item: sample_out actual %0d", m_sample_out);
                errors++;
            end else begin
                logic signed [15:0] exp_s;
                exp_s = expected_samples.pop_front();
                if (exp_s !== m_sample_out) begin
                    $error("sample_out mismatch: expected %0d actual %0d", exp_s, m_sample_out);
                    errors++;
                end
            end
        end
        if (!aresetn || hold_off) begin
            m_ready <= 1'b0;
            rx_gap <= 0;
        end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            m_ready <= 1'b0;
        end else if (m_valid && m_ready) begin
            m_ready <= 1'b0;
            rx_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [59:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            cbr_pkg::REG_WET: mdl_wet = val[16:0];
            cbr_pkg::REG_ROOM: mdl_room = val[16:0];
            cbr_pkg::REG_LEN_A, cbr_pkg::REG_LEN_B, cbr_pkg::REG_LEN_C, cbr_pkg::REG_LEN_D:
                mdl_len[idx - cbr_pkg::REG_LEN_A] = val[13:0];
            cbr_pkg::REG_COEFFS: mdl_coeffs = val;
            default: ;
        endcase
    endtask

    // sampled at the falling edge so the driver's updates have settled
    task automatic drain();
        do @(negedge aclk);
        while (pending_items.size() > 0 || s_valid || expected_samples.size() > 0);
        repeat (40) @(posedge aclk);
    endtask

    function automatic void add_random(int n);
        sample_item_t it;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 5))
                0: it.sample = 16'sh7FFF;
                1: it.sample = -16'sh8000;
                default: it.sample = 16'($urandom);
            endcase
            it.chan = 1'($urandom);
            pending_items.push_back(it);
        end
    endfunction

    function automatic logic [59:0] rand_coeffs();
        return {15'($urandom), 15'($urandom), 15'($urandom), 15'($urandom)};
    endfunction

    initial begin
        logic [13:0] short_len;
        mdl_wet = 0;
        mdl_room = 32768;
        mdl_len = '{14'd1000, 14'd1200, 14'd1400, 14'd1600};
        mdl_coeffs = '0;
        for (int s = 0; s < cbr_pkg::NumLines * cbr_pkg::NumChannels; s++) begin
            mdl_wpos[s] = 0;
            for (int p = 0; p < cbr_pkg::MaxDelay; p++) mdl_line[s][p] = '0;
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // bypass at reset wet level, extremes and both channels
        pending_items = '{'{16'sh7FFF, 1'b0}, '{-16'sh8000, 1'b1}, '{16'sh0001, 1'b0},
                          '{16'shFFFF, 1'b1}, '{16'sh5555, 1'b0}};
        drain();
        write_reg(cbr_pkg::REG_WET, 60'd65);
        pending_items = '{'{16'sh2AAA, 1'b1}};
        drain();

        // full wet, max feedback, shortest delays on three lines and the longest on the fourth
        write_reg(cbr_pkg::REG_WET, 60'd65536);
        write_reg(cbr_pkg::REG_ROOM, 60'd65536);
        write_reg(cbr_pkg::REG_COEFFS, {4{15'h7FFF}});
        write_reg(cbr_pkg::REG_LEN_A, 60'd1);
        write_reg(cbr_pkg::REG_LEN_B, 60'd2);
        write_reg(cbr_pkg::REG_LEN_C, 60'd3);
        write_reg(cbr_pkg::REG_LEN_D, 60'd16383);
        for (int i = 0; i < 18; i++)
            pending_items.push_back('{i[0] ? -16'sh8000 : 16'sh7FFF, i[1]});
        drain();

        // above-range levels count as full scale, a zero delay length as one
        write_reg(cbr_pkg::REG_WET, 60'h1FFFF);
        write_reg(cbr_pkg::REG_ROOM, 60'h1FFFF);
        write_reg(cbr_pkg::REG_LEN_A, 60'd0);
        add_random(10);
        drain();

        // random phases through a spread of settings
        for (int ph = 0; ph < 10; ph++) begin
            write_reg(cbr_pkg::REG_WET, ph == 3 ? 60'd66 : 60'($urandom_range(0, 70000)));
            write_reg(cbr_pkg::REG_ROOM, ph == 4 ? 60'd0 : 60'($urandom_range(0, 70000)));
            for (int k = 0; k < 4; k++) begin
                short_len = 14'($urandom_range(1, 40));
                write_reg(3'(cbr_pkg::REG_LEN_A + k),
                          ph == 9 ? 60'd16383 :
                          ($urandom_range(0, 7) == 0 ? 60'($urandom) : 60'(short_len)));
            end
            write_reg(cbr_pkg::REG_COEFFS, ph == 5 ? 60'd0 : rand_coeffs());
            if (ph == 6) begin
                // receiver stalls long while the sender keeps offering
                hold_off = 1'b1;
                add_random(20);
                repeat (600) @(posedge aclk);
                hold_off = 1'b0;
                add_random(130);
            end else begin
                add_random(150);
            end
            drain();
        end

        $display("covered %0d items in, %0d out: bypass, full wet, extreme delays and levels,",
                 n_sent, n_recv);
        $display("random settings per phase, and a long output stall with input backpressure");
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire

[files.f]
src/cbr_pkg.sv
src/comb_bank_reverb_unit.sv
tb/comb_bank_reverb_unit_test.sv
